/* hdl/drtd_pkg.sv */
package drtd_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;

   localparam int WORD_W      = 32;
   localparam int WATERMARK_W = 5;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 5;

   localparam logic [WATERMARK_W-1:0] WATERMARK_RESET = 5'd8;
   localparam logic                   SLEEP_EN_RESET  = 1'b1;

   localparam logic CMD_SCHEDULE = 1'b0;
   localparam logic CMD_RUN      = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_IRQ_WATERMARK = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLEEP_ENABLE  = 1'd1;

   localparam logic [1:0] KIND_STATUS   = 2'd0;
   localparam logic [1:0] KIND_DISPATCH = 2'd1;
   localparam logic [1:0] KIND_SLEEP    = 2'd2;

   localparam logic [1:0] ACT_NONE    = 2'd0;
   localparam logic [1:0] ACT_ENABLE  = 2'd1;
   localparam logic [1:0] ACT_DISABLE = 2'd2;

   typedef struct packed {
      logic [WORD_W-1:0] handle;
      logic [WORD_W-1:0] argument;
   } entry_type;

   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_STATUS,
      EMIT_IRQ,
      EMIT_NORM,
      EMIT_SLEEP
   } emit_type;

   typedef struct packed {
      logic     push;
      logic     pop_irq;
      logic     pop_norm;
      emit_type emit;
      logic     last;
   } dp_cmd_type;

   typedef struct packed {
      logic irq_nonempty;
      logic norm_nonempty;
      logic out_free;
      logic sleep_enable;
   } dp_status_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [WORD_W-1:0] out_handle;
      logic [WORD_W-1:0] out_argument;
      logic              accepted;
      logic [1:0]        irq_action;
      logic              from_irq_queue;
      logic              last;
   } rsp_beat_type;

endpackage

/* hdl/drtd_req_if.sv */
interface drtd_req_if;
   import drtd_pkg::*;

   logic              valid;
   logic              ready;
   logic              cmd;
   logic [WORD_W-1:0] task_handle;
   logic [WORD_W-1:0] task_argument;
   logic              interrupts_enabled;

   modport source (output valid, cmd, task_handle, task_argument, interrupts_enabled,
                   input ready);
   modport sink (input valid, cmd, task_handle, task_argument, interrupts_enabled,
                 output ready);
endinterface

/* hdl/drtd_rsp_if.sv */
interface drtd_rsp_if;
   import drtd_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        kind;
   logic [WORD_W-1:0] out_handle;
   logic [WORD_W-1:0] out_argument;
   logic              accepted;
   logic [1:0]        irq_action;
   logic              from_irq_queue;
   logic              last;

   modport source (output valid, kind, out_handle, out_argument, accepted, irq_action,
                   from_irq_queue, last, input ready);
   modport sink (input valid, kind, out_handle, out_argument, accepted, irq_action,
                 from_irq_queue, last, output ready);
endinterface

/* hdl/drtd_fifo.sv */
module drtd_fifo
   import drtd_pkg::*;
#(
   parameter  int DEPTH = DEFAULT_QUEUE_DEPTH,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic             pop,
   input  entry_type        push_data,
   output entry_type        head_data,
   output logic [CNT_W-1:0] count,
   output logic             full
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int SUM_W = PTR_W + 1;

   entry_type        mem [DEPTH];
   entry_type        head_ff;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] wr_sum;
   logic [PTR_W-1:0] wr_addr;
   logic             push_ok;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign push_ok = push && !full;
   assign wr_sum  = SUM_W'(rd_ptr_ff) + SUM_W'(count_ff);
   assign wr_addr = (wr_sum >= SUM_W'(DEPTH)) ? PTR_W'(wr_sum - SUM_W'(DEPTH))
                                              : PTR_W'(wr_sum);

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop) begin
         count_in  = count_ff - 1'b1;
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem[wr_addr] <= push_data;
      end
      head_ff <= mem[rd_ptr_ff];
   end

   assign head_data = head_ff;
   assign count     = count_ff;

endmodule

/* hdl/drtd_datapath.sv */
module drtd_datapath
   import drtd_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic [WORD_W-1:0]      task_handle,
   input  logic [WORD_W-1:0]      task_argument,
   input  logic                   interrupts_enabled,
   input  dp_cmd_type             ctl,
   output dp_status_type          sts,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output rsp_beat_type           rsp_beat
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > WATERMARK_W) ? CNT_W : WATERMARK_W;

   logic [WATERMARK_W-1:0] watermark_ff;
   logic                   sleep_en_ff;
   logic                   valid_ff, valid_in;
   rsp_beat_type           beat_ff, beat_in;

   entry_type        new_entry, irq_head, norm_head;
   logic [CNT_W-1:0] irq_count, norm_count;
   logic             irq_full, norm_full;
   logic             irq_push, norm_push;
   logic             chosen_full;
   logic [1:0]       irq_act;

   assign new_entry   = '{handle: task_handle, argument: task_argument};
   assign norm_push   = ctl.push && interrupts_enabled;
   assign irq_push    = ctl.push && !interrupts_enabled;
   assign chosen_full = interrupts_enabled ? norm_full : irq_full;

   drtd_fifo #(.DEPTH(QUEUE_DEPTH)) u_irq_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (irq_push),
      .pop       (ctl.pop_irq),
      .push_data (new_entry),
      .head_data (irq_head),
      .count     (irq_count),
      .full      (irq_full)
   );

   drtd_fifo #(.DEPTH(QUEUE_DEPTH)) u_norm_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (norm_push),
      .pop       (ctl.pop_norm),
      .push_data (new_entry),
      .head_data (norm_head),
      .count     (norm_count),
      .full      (norm_full)
   );

   // fill counted includes the entry on its way out
   assign irq_act = (CMP_W'(irq_count) >= CMP_W'(watermark_ff)) ? ACT_DISABLE : ACT_ENABLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         watermark_ff <= WATERMARK_RESET;
         sleep_en_ff  <= SLEEP_EN_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IRQ_WATERMARK: watermark_ff <= csr_write_data[WATERMARK_W-1:0];
            CSR_SLEEP_ENABLE:  sleep_en_ff  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      beat_in  = beat_ff;
      if (ctl.emit != EMIT_NONE) begin
         valid_in = 1'b1;
         beat_in  = '0;
         beat_in.last = ctl.last;
      end
      unique case (ctl.emit)
         EMIT_NONE: ;
         EMIT_STATUS: begin
            beat_in.kind     = KIND_STATUS;
            beat_in.accepted = !chosen_full;
         end
         EMIT_IRQ: begin
            beat_in.kind           = KIND_DISPATCH;
            beat_in.out_handle     = irq_head.handle;
            beat_in.out_argument   = irq_head.argument;
            beat_in.irq_action     = irq_act;
            beat_in.from_irq_queue = 1'b1;
         end
         EMIT_NORM: begin
            beat_in.kind         = KIND_DISPATCH;
            beat_in.out_handle   = norm_head.handle;
            beat_in.out_argument = norm_head.argument;
         end
         EMIT_SLEEP: begin
            beat_in.kind = KIND_SLEEP;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

   assign sts.irq_nonempty  = (irq_count != '0);
   assign sts.norm_nonempty = (norm_count != '0);
   assign sts.out_free      = !valid_ff || rsp_ready;
   assign sts.sleep_enable  = sleep_en_ff;

   assign rsp_valid = valid_ff;
   assign rsp_beat  = beat_ff;

endmodule

/* hdl/drtd_ctrl.sv */
module drtd_ctrl
   import drtd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_cmd,
   output logic          req_ready,
   input  dp_status_type sts,
   output dp_cmd_type    ctl
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_IRQ,
      S_NORM
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE) && sts.out_free;

   always_comb begin
      state_in = state_ff;
      ctl      = '{push: 1'b0, pop_irq: 1'b0, pop_norm: 1'b0, emit: EMIT_NONE, last: 1'b0};
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               if (req_cmd == CMD_SCHEDULE) begin
                  ctl.push = 1'b1;
                  ctl.emit = EMIT_STATUS;
                  ctl.last = 1'b1;
               end else begin
                  state_in = S_IRQ;
               end
            end
         end
         S_IRQ: begin
            if (sts.out_free) begin
               priority if (sts.irq_nonempty) begin
                  ctl.emit    = EMIT_IRQ;
                  ctl.pop_irq = 1'b1;
                  ctl.last    = !sts.norm_nonempty;
                  state_in    = sts.norm_nonempty ? S_NORM : S_IDLE;
               end else if (sts.norm_nonempty) begin
                  ctl.emit     = EMIT_NORM;
                  ctl.pop_norm = 1'b1;
                  ctl.last     = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  if (sts.sleep_enable) begin
                     ctl.emit = EMIT_SLEEP;
                     ctl.last = 1'b1;
                  end
                  state_in = S_IDLE;
               end
            end
         end
         S_NORM: begin
            if (sts.out_free) begin
               ctl.emit     = EMIT_NORM;
               ctl.pop_norm = 1'b1;
               ctl.last     = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hdl/dual_ring_task_dispatcher.sv */
// Two-level task dispatcher: a normal queue and an interrupt-context queue of QUEUE_DEPTH
// descriptors each. A schedule beat yields one status beat. A run beat yields one result or
// none, and two when it dispatches from both queues; each queue memory has a registered
// read port, and the controller issues one result per cycle into the output register while
// the result channel is not stalled. A stalled result channel holds the controller in place.
// Queue memories need no clearing after reset.
module dual_ring_task_dispatcher
   import drtd_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   drtd_req_if.sink               req_if,
   drtd_rsp_if.source             rsp_if,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   dp_cmd_type    ctl;
   dp_status_type sts;
   rsp_beat_type  beat;

   drtd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_cmd   (req_if.cmd),
      .req_ready (req_if.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   drtd_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .task_handle        (req_if.task_handle),
      .task_argument      (req_if.task_argument),
      .interrupts_enabled (req_if.interrupts_enabled),
      .ctl                (ctl),
      .sts                (sts),
      .rsp_ready          (rsp_if.ready),
      .rsp_valid          (rsp_if.valid),
      .rsp_beat           (beat)
   );

   assign rsp_if.kind           = beat.kind;
   assign rsp_if.out_handle     = beat.out_handle;
   assign rsp_if.out_argument   = beat.out_argument;
   assign rsp_if.accepted       = beat.accepted;
   assign rsp_if.irq_action     = beat.irq_action;
   assign rsp_if.from_irq_queue = beat.from_irq_queue;
   assign rsp_if.last           = beat.last;

endmodule

/* hdl/drtd_checker.sv */
module drtd_checker
   import drtd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [1:0]        rsp_kind,
   input logic [WORD_W-1:0] rsp_out_handle,
   input logic [WORD_W-1:0] rsp_out_argument,
   input logic              rsp_accepted,
   input logic [1:0]        rsp_irq_action,
   input logic              rsp_from_irq_queue,
   input logic              rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_STATUS || rsp_kind == KIND_DISPATCH ||
                     rsp_kind == KIND_SLEEP))
      else $error("illegal result kind");

   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_DISPATCH |->
         rsp_out_handle == '0 && rsp_out_argument == '0 &&
         rsp_irq_action == ACT_NONE && !rsp_from_irq_queue)
      else $error("dispatch fields set on a non-dispatch beat");

   a_accepted_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_STATUS |-> !rsp_accepted)
      else $error("accepted set outside a status beat");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_STATUS || rsp_kind == KIND_SLEEP) |-> rsp_last)
      else $error("single-beat result not marked last");

endmodule

bind dual_ring_task_dispatcher drtd_checker u_drtd_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_kind           (rsp_if.kind),
   .rsp_out_handle     (rsp_if.out_handle),
   .rsp_out_argument   (rsp_if.out_argument),
   .rsp_accepted       (rsp_if.accepted),
   .rsp_irq_action     (rsp_if.irq_action),
   .rsp_from_irq_queue (rsp_if.from_irq_queue),
   .rsp_last           (rsp_if.last)
);

/* test/drtd_checker.sv */
module drtd_tb_checker
   import drtd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   drtd_req_if                    req_mon,
   drtd_rsp_if                    rsp_mon,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output int                     pending,
   output int                     failures
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH     = DEFAULT_QUEUE_DEPTH;
   localparam int IRQ_RING  = 0;
   localparam int NORM_RING = 1;
   localparam int MAX_SHOWN = 10;

   entry_type              ring [2][DEPTH];
   int                     ring_head [2];
   int                     ring_fill [2];
   logic [WATERMARK_W-1:0] watermark;
   logic                   sleep_en;
   rsp_beat_type           awaited_beats [$];
   int                     mismatches;

   function automatic string show_beat(input rsp_beat_type b);
      return $sformatf("kind=%0d handle=%08h arg=%08h acc=%0d act=%0d irq=%0d last=%0d",
                       b.kind, b.out_handle, b.out_argument, b.accepted, b.irq_action,
                       b.from_irq_queue, b.last);
   endfunction

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_SHOWN)
         $display("%0t: %s", $realtime, msg);
   endtask

   function automatic rsp_beat_type take_head(input int r);
      rsp_beat_type b;
      entry_type    e;
      e = ring[r][ring_head[r]];
      ring_head[r] = (ring_head[r] + 1) % DEPTH;
      ring_fill[r]--;
      b = '0;
      b.kind = KIND_DISPATCH;
      b.out_handle = e.handle;
      b.out_argument = e.argument;
      return b;
   endfunction

   task automatic predict_dispatch(input logic cmd, input entry_type e, input logic ie);
      rsp_beat_type b;
      rsp_beat_type outs [$];
      int           r;
      if (cmd == CMD_SCHEDULE) begin
         r = ie ? NORM_RING : IRQ_RING;
         b = '0;
         b.kind = KIND_STATUS;
         if (ring_fill[r] < DEPTH) begin
            ring[r][(ring_head[r] + ring_fill[r]) % DEPTH] = e;
            ring_fill[r]++;
            b.accepted = 1'b1;
         end
         outs.push_back(b);
      end else begin
         if (ring_fill[IRQ_RING] > 0) begin
            // fill counted includes the entry going out
            r = ring_fill[IRQ_RING];
            b = take_head(IRQ_RING);
            b.irq_action = (r >= int'(watermark)) ? ACT_DISABLE : ACT_ENABLE;
            b.from_irq_queue = 1'b1;
            outs.push_back(b);
         end
         if (ring_fill[NORM_RING] > 0)
            outs.push_back(take_head(NORM_RING));
         if (outs.size() == 0 && sleep_en) begin
            b = '0;
            b.kind = KIND_SLEEP;
            outs.push_back(b);
         end
      end
      foreach (outs[i]) begin
         b = outs[i];
         b.last = (i == outs.size() - 1);
         awaited_beats.push_back(b);
      end
   endtask

   always @(posedge clock) begin
      rsp_beat_type got;
      rsp_beat_type want;
      entry_type    e;
      if (reset) begin
         for (int r = 0; r < 2; r++) begin
            ring_head[r] = 0;
            ring_fill[r] = 0;
         end
         watermark = WATERMARK_RESET;
         sleep_en = SLEEP_EN_RESET;
         awaited_beats.delete();
         mismatches = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.kind = rsp_mon.kind;
            got.out_handle = rsp_mon.out_handle;
            got.out_argument = rsp_mon.out_argument;
            got.accepted = rsp_mon.accepted;
            got.irq_action = rsp_mon.irq_action;
            got.from_irq_queue = rsp_mon.from_irq_queue;
            got.last = rsp_mon.last;
            if (awaited_beats.size() == 0) begin
               note_mismatch({"unexpected beat: ", show_beat(got)});
            end else begin
               want = awaited_beats.pop_front();
               if (got.kind !== want.kind || got.out_handle !== want.out_handle ||
                   got.out_argument !== want.out_argument || got.accepted !== want.accepted ||
                   got.irq_action !== want.irq_action ||
                   got.from_irq_queue !== want.from_irq_queue || got.last !== want.last)
                  note_mismatch({"beat mismatch\n  expected ", show_beat(want),
                                 "\n  actual   ", show_beat(got)});
            end
         end
         if (csr_write_enable) begin
            if (csr_index == CSR_IRQ_WATERMARK)
               watermark = csr_write_data[WATERMARK_W-1:0];
            else if (csr_index == CSR_SLEEP_ENABLE)
               sleep_en = csr_write_data[0];
         end
         if (req_mon.valid && req_mon.ready) begin
            e.handle = req_mon.task_handle;
            e.argument = req_mon.task_argument;
            predict_dispatch(req_mon.cmd, e, req_mon.interrupts_enabled);
         end
      end
      pending <= awaited_beats.size();
      failures <= mismatches;
   end

endmodule

/* test/testbench.sv */
module testbench;
   import drtd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASE_BEATS   = 92;
   localparam int BURST_LEN     = 24;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 300;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   int                     pending;
   int                     failures;
   bit                     calm;
   bit                     hold_req;

   drtd_req_if req_bus ();
   drtd_rsp_if rsp_bus ();

   dual_ring_task_dispatcher DUT (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_bus),
      .rsp_if           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   drtd_tb_checker scoreboard (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .pending          (pending),
      .failures         (failures)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // result side: random back-pressure, quiet stretches, one long hold-off
   initial begin
      bit held;
      held = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !held) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held = 1'b1;
         end else if (calm) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= 10);
         end
      end
   end

   task automatic send_beat(input logic cmd, input logic [WORD_W-1:0] handle,
                            input logic [WORD_W-1:0] argument, input logic ie);
      if (!calm && $urandom_range(0, 99) < 10) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= cmd;
      req_bus.task_handle <= handle;
      req_bus.task_argument <= argument;
      req_bus.interrupts_enabled <= ie;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(input logic [CSR_DATA_W-1:0] wm, input logic sleep,
                            input bit with_hold, input bit quiet);
      int   sched_pct;
      int   route;
      logic ie;
      drain_results();
      write_csr(CSR_IRQ_WATERMARK, wm);
      write_csr(CSR_SLEEP_ENABLE, {(CSR_DATA_W-1)'($urandom_range(0, 15)), sleep});
      calm = quiet;
      for (int i = 0; i < PHASE_BEATS; i++) begin
         if (i % BURST_LEN == 0) begin
            // alternate fill-up and drain-down bursts
            sched_pct = ((i / BURST_LEN) % 2 == 0) ? 85 : 20;
            route = $urandom_range(0, 2);
         end
         if (with_hold && i == 20)
            hold_req = 1'b1;
         ie = (route == 2) ? 1'($urandom_range(0, 1)) : 1'(route);
         send_beat(($urandom_range(0, 99) < sched_pct) ? CMD_SCHEDULE : CMD_RUN,
                   $urandom, $urandom, ie);
      end
      calm = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      calm = 1'b0;
      hold_req = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_IRQ_WATERMARK;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.cmd = CMD_SCHEDULE;
      req_bus.task_handle = '0;
      req_bus.task_argument = '0;
      req_bus.interrupts_enabled = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // idle run with sleep off gives nothing, with sleep on a sleep request
      write_csr(CSR_SLEEP_ENABLE, 5'h1e);
      send_beat(CMD_RUN, '0, '0, 1'b0);
      drain_results();
      write_csr(CSR_SLEEP_ENABLE, 5'h01);
      send_beat(CMD_RUN, '1, '1, 1'b1);
      drain_results();

      // watermark zero always disables; extreme words
      write_csr(CSR_IRQ_WATERMARK, 5'd0);
      send_beat(CMD_SCHEDULE, 32'h0000_0000, 32'hffff_ffff, 1'b1);
      send_beat(CMD_SCHEDULE, 32'hffff_ffff, 32'h0000_0000, 1'b0);
      send_beat(CMD_RUN, '0, '0, 1'b0);
      drain_results();

      // watermark at depth: enable below full
      write_csr(CSR_IRQ_WATERMARK, 5'd16);
      send_beat(CMD_SCHEDULE, 32'h5555_5555, 32'haaaa_aaaa, 1'b0);
      send_beat(CMD_SCHEDULE, 32'haaaa_aaaa, 32'h5555_5555, 1'b0);
      send_beat(CMD_SCHEDULE, 32'h1234_5678, 32'h9abc_def0, 1'b0);
      send_beat(CMD_SCHEDULE, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 1'b1);
      send_beat(CMD_RUN, '0, '0, 1'b0);
      send_beat(CMD_RUN, '0, '0, 1'b1);
      send_beat(CMD_RUN, '0, '0, 1'b0);
      drain_results();

      // crossing the watermark on the way down
      write_csr(CSR_IRQ_WATERMARK, 5'd2);
      send_beat(CMD_SCHEDULE, $urandom, $urandom, 1'b0);
      send_beat(CMD_SCHEDULE, $urandom, $urandom, 1'b0);
      send_beat(CMD_SCHEDULE, $urandom, $urandom, 1'b0);
      send_beat(CMD_RUN, '0, '0, 1'b0);
      send_beat(CMD_RUN, '0, '0, 1'b0);
      send_beat(CMD_RUN, '0, '0, 1'b0);
      send_beat(CMD_RUN, '0, '0, 1'b0);

      run_phase(5'd8, 1'b1, 1'b0, 1'b0);
      run_phase(5'd1, 1'b0, 1'b1, 1'b0);
      run_phase(5'd31, 1'b1, 1'b0, 1'b0);
      run_phase(5'd0, 1'b0, 1'b0, 1'b1);
      run_phase(5'd16, 1'b1, 1'b0, 1'b0);
      run_phase(5'd17, 1'b1, 1'b0, 1'b0);
      run_phase(CSR_DATA_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), 1'b0, 1'b0);
      run_phase(5'd15, 1'b0, 1'b0, 1'b0);

      drain_results();
      if (failures == 0 && pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

/* sim.f */
hdl/drtd_pkg.sv
hdl/drtd_req_if.sv
hdl/drtd_rsp_if.sv
hdl/drtd_fifo.sv
hdl/drtd_datapath.sv
hdl/drtd_ctrl.sv
hdl/dual_ring_task_dispatcher.sv
hdl/drtd_checker.sv
test/drtd_checker.sv
test/testbench.sv
